// File: rtl/tfvd_pkg.sv
// ----------------------------------------------------------------------------
// tfvd_pkg
// Type codes, widths and helpers for the TIFF field value decoder.
// ----------------------------------------------------------------------------
package tfvd_pkg;

  // TIFF field type codes
  localparam logic [15:0] TYPE_BYTE      = 16'd1;
  localparam logic [15:0] TYPE_ASCII     = 16'd2;
  localparam logic [15:0] TYPE_SHORT     = 16'd3;
  localparam logic [15:0] TYPE_LONG      = 16'd4;
  localparam logic [15:0] TYPE_RATIONAL  = 16'd5;
  localparam logic [15:0] TYPE_SBYTE     = 16'd6;
  localparam logic [15:0] TYPE_UNDEFINED = 16'd7;
  localparam logic [15:0] TYPE_SSHORT    = 16'd8;
  localparam logic [15:0] TYPE_SLONG     = 16'd9;
  localparam logic [15:0] TYPE_SRATIONAL = 16'd10;
  localparam logic [15:0] TYPE_FLOAT     = 16'd11;
  localparam logic [15:0] TYPE_DOUBLE    = 16'd12;
  localparam logic [15:0] TYPE_IFD       = 16'd13;
  localparam logic [15:0] TYPE_LONG8     = 16'd16;
  localparam logic [15:0] TYPE_SLONG8    = 16'd17;
  localparam logic [15:0] TYPE_IFD8      = 16'd18;

  // Element sizes in bytes
  localparam logic [3:0] SIZE_NONE = 4'd0;
  localparam logic [3:0] SIZE_1    = 4'd1;
  localparam logic [3:0] SIZE_2    = 4'd2;
  localparam logic [3:0] SIZE_4    = 4'd4;
  localparam logic [3:0] SIZE_8    = 4'd8;

  // Byte order register values
  localparam logic ORDER_LE = 1'b0;
  localparam logic ORDER_BE = 1'b1;

  localparam int IN_W  = 144;
  localparam int OUT_W = 208;

  // Bytes per element for a type code
  function automatic logic [3:0] size_of_type(input logic [15:0] t);
    logic [3:0] s;
    case (t) inside
      TYPE_BYTE, TYPE_ASCII, TYPE_SBYTE, TYPE_UNDEFINED: s = SIZE_1;
      TYPE_SHORT, TYPE_SSHORT:                            s = SIZE_2;
      TYPE_LONG, TYPE_SLONG, TYPE_FLOAT, TYPE_IFD:        s = SIZE_4;
      TYPE_RATIONAL, TYPE_SRATIONAL, TYPE_DOUBLE,
      TYPE_LONG8, TYPE_SLONG8, TYPE_IFD8:                 s = SIZE_8;
      default:                                            s = SIZE_NONE;
    endcase
    return s;
  endfunction

  function automatic logic [31:0] bswap32(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  // Stage 1 -> stage 2: decoded type and range checks
  typedef struct packed {
    logic [3:0]  sz;
    logic        is_uns;
    logic        is_sgn;
    logic        is_srat;
    logic        ok;
    logic        rat_ok;
    logic        order;
    logic [63:0] raw;
  } s1_t;

  // Stage 2 -> stage 3: assembled readings
  typedef struct packed {
    logic [3:0]  sz;
    logic        is_uns;
    logic        is_sgn;
    logic        ok;
    logic        rat_ok;
    logic [63:0] rd;
    logic [63:0] rd_sx;
    logic [32:0] num;
    logic [32:0] den;
  } s2_t;

  // Stage 3: result beat
  typedef struct packed {
    logic [32:0] den;
    logic [32:0] num;
    logic        r_ok;
    logic [63:0] s_val;
    logic        s_ok;
    logic [63:0] u_val;
    logic        u_ok;
    logic [3:0]  sz;
  } res_t;

endpackage

// File: rtl/tiff_field_value_decoder.sv
// Throughput: one beat per cycle while out_tready is high; three register
// stages (decode and range check, byte assembly, flag and result select)
// each hold one item. A stalled stage holds its item; upstream stages fill
// any bubbles. Reset (rst_n low, synchronous) empties the pipeline and
// sets little endian.
// ----------------------------------------------------------------------------
// tiff_field_value_decoder
// Decodes one element of a TIFF directory entry as unsigned, signed and
// rational readings, with bounds checks against count and buffer length.
// ----------------------------------------------------------------------------
module tiff_field_value_decoder
  import tfvd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  // configuration
  input  logic             cfg_wr_en,
  input  logic             cfg_wr_data,    // file order: 0 little, 1 big endian
  // input stream
  input  logic             in_tvalid,
  output logic             in_tready,
  // field_type[15:0], elem_index[31:16], entry_count[63:32],
  // value_length[79:64], element_bytes[143:80]
  input  logic [IN_W-1:0]  in_tdata,
  // result stream
  output logic             out_tvalid,
  input  logic             out_tready,
  // elem_size[3:0], unsigned_ok[4], unsigned_val[68:5], signed_ok[69],
  // signed_val[133:70], rational_ok[134], rat_numerator[167:135],
  // rat_denominator[200:168], zero pad[207:201]
  output logic [OUT_W-1:0] out_tdata
);

  logic        endian_r;
  logic        v1_r, v2_r, v3_r;
  s1_t         s1_r, s1_nxt;
  s2_t         s2_r, s2_nxt;
  res_t        s3_r, s3_nxt;
  logic        adv1, adv2, adv3;

  logic [15:0] f_type;
  logic [15:0] f_idx;
  logic [31:0] f_cnt;
  logic [15:0] f_len;
  logic [16:0] idx_p1;
  logic [19:0] span;
  logic        in_cnt;

  assign f_type = in_tdata[15:0];
  assign f_idx  = in_tdata[31:16];
  assign f_cnt  = in_tdata[63:32];
  assign f_len  = in_tdata[79:64];

  // Stage handshake: a stage moves when empty or when the next one moves
  assign adv3      = !v3_r || out_tready;
  assign adv2      = !v2_r || adv3;
  assign adv1      = !v1_r || adv2;
  assign in_tready = adv1;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      endian_r <= ORDER_LE;
    end else if (cfg_wr_en) begin
      endian_r <= cfg_wr_data;
    end
  end

  // Stage 1: type decode and range checks
  always_comb begin
    idx_p1 = {1'b0, f_idx} + 17'd1;
    s1_nxt.sz = size_of_type(f_type);
    case (s1_nxt.sz)
      SIZE_1:  span = {3'b0, idx_p1};
      SIZE_2:  span = {2'b0, idx_p1, 1'b0};
      SIZE_4:  span = {1'b0, idx_p1, 2'b0};
      SIZE_8:  span = {idx_p1, 3'b0};
      default: span = '0;
    endcase
    in_cnt = {16'b0, f_idx} < f_cnt;
    case (f_type) inside
      TYPE_BYTE, TYPE_UNDEFINED, TYPE_SHORT, TYPE_LONG,
      TYPE_IFD, TYPE_LONG8, TYPE_IFD8: s1_nxt.is_uns = 1'b1;
      default:                         s1_nxt.is_uns = 1'b0;
    endcase
    case (f_type) inside
      TYPE_SBYTE, TYPE_SSHORT, TYPE_SLONG, TYPE_SLONG8: s1_nxt.is_sgn = 1'b1;
      default:                                          s1_nxt.is_sgn = 1'b0;
    endcase
    s1_nxt.is_srat = (f_type == TYPE_SRATIONAL);
    s1_nxt.ok      = (s1_nxt.sz != SIZE_NONE) && in_cnt && (span <= {4'b0, f_len});
    s1_nxt.rat_ok  = ((f_type == TYPE_RATIONAL) || (f_type == TYPE_SRATIONAL)) &&
                     in_cnt && ({idx_p1, 3'b0} <= {4'b0, f_len});
    s1_nxt.order   = endian_r;
    s1_nxt.raw     = in_tdata[143:80];
  end

  // Stage 2: assemble bytes in file order and sign-extend
  always_comb begin
    logic [63:0] raw;
    logic        be;
    raw = s1_r.raw;
    be  = (s1_r.order == ORDER_BE);
    s2_nxt.sz     = s1_r.sz;
    s2_nxt.is_uns = s1_r.is_uns;
    s2_nxt.is_sgn = s1_r.is_sgn;
    s2_nxt.ok     = s1_r.ok;
    case (s1_r.sz)
      SIZE_1: begin
        s2_nxt.rd    = {56'b0, raw[7:0]};
        s2_nxt.rd_sx = {{56{raw[7]}}, raw[7:0]};
      end
      SIZE_2: begin
        s2_nxt.rd    = be ? {48'b0, raw[7:0], raw[15:8]} : {48'b0, raw[15:0]};
        s2_nxt.rd_sx = be ? {{48{raw[7]}}, raw[7:0], raw[15:8]}
                          : {{48{raw[15]}}, raw[15:0]};
      end
      SIZE_4: begin
        s2_nxt.rd    = be ? {32'b0, bswap32(raw[31:0])} : {32'b0, raw[31:0]};
        s2_nxt.rd_sx = be ? {{32{raw[7]}}, bswap32(raw[31:0])}
                          : {{32{raw[31]}}, raw[31:0]};
      end
      SIZE_8: begin
        s2_nxt.rd    = be ? {bswap32(raw[31:0]), bswap32(raw[63:32])} : raw;
        s2_nxt.rd_sx = s2_nxt.rd;
      end
      default: begin
        s2_nxt.rd    = '0;
        s2_nxt.rd_sx = '0;
      end
    endcase
    // rational: numerator from bytes 0..3, denominator from bytes 4..7
    begin
      logic [31:0] n, d;
      n = be ? bswap32(raw[31:0])  : raw[31:0];
      d = be ? bswap32(raw[63:32]) : raw[63:32];
      s2_nxt.num    = {s1_r.is_srat & n[31], n};
      s2_nxt.den    = {s1_r.is_srat & d[31], d};
      s2_nxt.rat_ok = s1_r.rat_ok && (d != 32'd0);
    end
  end

  // Stage 3: validity flags and zeroing of invalid readings
  always_comb begin
    logic u_ok, s_ok;
    u_ok = s2_r.ok && s2_r.is_uns;
    s_ok = s2_r.ok && (s2_r.is_sgn || (s2_r.is_uns && !s2_r.rd[63]));
    s3_nxt.sz    = s2_r.sz;
    s3_nxt.u_ok  = u_ok;
    s3_nxt.u_val = u_ok ? s2_r.rd : '0;
    s3_nxt.s_ok  = s_ok;
    s3_nxt.s_val = !s_ok ? '0 : (s2_r.is_sgn ? s2_r.rd_sx : s2_r.rd);
    s3_nxt.r_ok  = s2_r.rat_ok;
    s3_nxt.num   = s2_r.rat_ok ? s2_r.num : '0;
    s3_nxt.den   = s2_r.rat_ok ? s2_r.den : '0;
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (adv1) begin
        v1_r <= in_tvalid;
      end
      if (adv2) begin
        v2_r <= v1_r;
      end
      if (adv3) begin
        v3_r <= v2_r;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (adv1 && in_tvalid) begin
      s1_r <= s1_nxt;
    end
    if (adv2 && v1_r) begin
      s2_r <= s2_nxt;
    end
    if (adv3 && v2_r) begin
      s3_r <= s3_nxt;
    end
  end

  assign out_tvalid = v3_r;
  assign out_tdata  = {7'b0, s3_r};

`ifndef SYNTHESIS
  // a valid rational never carries a zero denominator
  a_rat_den: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && s3_r.r_ok) |-> (s3_r.den != 33'd0))
    else $error("rational valid with zero denominator");

  // an unsigned reading below 2^63 always has a signed reading
  a_fallback: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && s3_r.u_ok && !s3_r.u_val[63]) |-> s3_r.s_ok)
    else $error("signed fallback missing");

  // unknown type gives no valid reading
  a_unknown: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && (s3_r.sz == SIZE_NONE)) |-> (!s3_r.u_ok && !s3_r.s_ok && !s3_r.r_ok))
    else $error("reading valid for unknown type");

  // a stalled middle stage keeps its item
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && !adv3) |=> (v2_r && $stable(s2_r)))
    else $error("stage 2 item lost under stall");
`endif

endmodule

// File: tb/tb_tiff_field_value_decoder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tiff_field_value_decoder
// Self-checking bench for the TIFF field value decoder. Each accepted input
// beat is decoded by a local predictor and queued; each result beat is
// compared field by field with the oldest queued reading. Directed cases come
// first, then random entries in both byte orders under random sender gaps,
// receiver stalls, a long output hold and pauses until the pipeline drains.
// ----------------------------------------------------------------------------
module tb_tiff_field_value_decoder;
  import tfvd_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_TAIL     = 6;
  localparam int MAX_PRINTS     = 40;

  // Codes with no defined element size
  localparam logic [15:0] TYPE_NONE_0  = 16'd0;
  localparam logic [15:0] TYPE_GAP_14  = 16'd14;
  localparam logic [15:0] TYPE_GAP_15  = 16'd15;
  localparam logic [15:0] TYPE_PAST_18 = 16'd19;

  // Raw bytes for the directed sweep: sign bits set, nonzero denominator
  localparam logic [63:0] SWEEP_RAW = 64'h8123_4567_F0E1_D2C3;

  // One input beat, field_type in the lowest bits
  typedef struct packed {
    logic [63:0] raw;
    logic [15:0] len;
    logic [31:0] cnt;
    logic [15:0] idx;
    logic [15:0] ftype;
  } entry_t;

  typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_wr_en;
  logic             cfg_wr_data;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;

  res_t     expected_readings[$];
  res_t     got_res;
  res_t     want_res;
  logic     file_order;
  int       error_count;
  int       quiet_cycles;
  int       burst_left;
  bit       tx_gaps;
  rx_mode_t rx_mode;
  int       rx_tick;
  int       hold_req;
  int       hold_seen;
  int       hold_left;

  tiff_field_value_decoder u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  // 20 ns clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Bytes per element, 0 for a code outside the table
  function automatic int unsigned type_bytes(input logic [15:0] t);
    case (t)
      TYPE_BYTE, TYPE_ASCII, TYPE_SBYTE, TYPE_UNDEFINED: return 1;
      TYPE_SHORT, TYPE_SSHORT:                            return 2;
      TYPE_LONG, TYPE_SLONG, TYPE_FLOAT, TYPE_IFD:        return 4;
      TYPE_RATIONAL, TYPE_SRATIONAL, TYPE_DOUBLE,
      TYPE_LONG8, TYPE_SLONG8, TYPE_IFD8:                 return 8;
      default:                                            return 0;
    endcase
  endfunction

  // Assemble n bytes from byte offset off in the given file order
  function automatic logic [63:0] gather_bytes(input logic order, input logic [63:0] raw,
                                               input int unsigned off, input int unsigned n);
    logic [63:0] v;
    logic [7:0]  b;
    v = '0;
    for (int i = 0; i < n; i++) begin
      b = raw[8 * ((off + i) % 8) +: 8];
      if (order == ORDER_BE) v = {v[55:0], b};
      else v[8 * i +: 8] = b;
    end
    return v;
  endfunction

  // Expected result beat for one directory entry element
  function automatic res_t decode_element(input logic order, input entry_t e);
    res_t                r;
    int unsigned         sz;
    int unsigned         need;
    logic                in_bounds;
    logic [63:0]         rd;
    logic [63:0]         n;
    logic [63:0]         d;
    logic signed [63:0]  t;
    r = '0;
    sz = type_bytes(e.ftype);
    need = (32'(e.idx) + 1) * sz;
    in_bounds = (sz != 0) && (32'(e.idx) < e.cnt) && (need <= 32'(e.len));
    r.sz = sz[3:0];
    if (in_bounds) begin
      rd = gather_bytes(order, e.raw, 0, sz);
      case (e.ftype)
        TYPE_BYTE, TYPE_UNDEFINED, TYPE_SHORT, TYPE_LONG, TYPE_IFD, TYPE_LONG8, TYPE_IFD8: begin
          r.u_ok  = 1'b1;
          r.u_val = rd;
        end
        default: ;
      endcase
      case (e.ftype)
        TYPE_SBYTE, TYPE_SSHORT, TYPE_SLONG, TYPE_SLONG8: begin
          t       = $signed(rd << (64 - 8 * sz));
          r.s_ok  = 1'b1;
          r.s_val = t >>> (64 - 8 * sz);
        end
        default: begin
          // unsigned types fall back when the value fits in int64
          if (r.u_ok && !rd[63]) begin
            r.s_ok  = 1'b1;
            r.s_val = rd;
          end
        end
      endcase
      if (e.ftype == TYPE_RATIONAL || e.ftype == TYPE_SRATIONAL) begin
        n = gather_bytes(order, e.raw, 0, 4);
        d = gather_bytes(order, e.raw, 4, 4);
        if (d[31:0] != 32'd0) begin
          r.r_ok = 1'b1;
          if (e.ftype == TYPE_SRATIONAL) begin
            r.num = {n[31], n[31:0]};
            r.den = {d[31], d[31:0]};
          end else begin
            r.num = {1'b0, n[31:0]};
            r.den = {1'b0, d[31:0]};
          end
        end
      end
    end
    return r;
  endfunction

  function automatic entry_t make_item(input logic [15:0] ftype, input logic [15:0] idx,
                                       input logic [31:0] cnt, input logic [15:0] len,
                                       input logic [63:0] raw);
    entry_t e;
    e.ftype = ftype;
    e.idx   = idx;
    e.cnt   = cnt;
    e.len   = len;
    e.raw   = raw;
    return e;
  endfunction

  // Random entry: mostly in bounds, some out of count or buffer, some noise
  function automatic entry_t make_entry();
    entry_t      e;
    int unsigned kind;
    int unsigned bytes;
    int unsigned need;
    int unsigned slack;
    case ($urandom_range(0, 19))
      0:       e.ftype = TYPE_BYTE;
      1:       e.ftype = TYPE_ASCII;
      2:       e.ftype = TYPE_SHORT;
      3:       e.ftype = TYPE_LONG;
      4:       e.ftype = TYPE_RATIONAL;
      5:       e.ftype = TYPE_SBYTE;
      6:       e.ftype = TYPE_UNDEFINED;
      7:       e.ftype = TYPE_SSHORT;
      8:       e.ftype = TYPE_SLONG;
      9:       e.ftype = TYPE_SRATIONAL;
      10:      e.ftype = TYPE_FLOAT;
      11:      e.ftype = TYPE_DOUBLE;
      12:      e.ftype = TYPE_IFD;
      13:      e.ftype = TYPE_LONG8;
      14:      e.ftype = TYPE_SLONG8;
      15:      e.ftype = TYPE_IFD8;
      16:      e.ftype = TYPE_NONE_0;
      17:      e.ftype = TYPE_GAP_14;
      18:      e.ftype = TYPE_GAP_15;
      default: e.ftype = TYPE_PAST_18;
    endcase
    if ($urandom_range(0, 15) == 0) e.ftype = 16'($urandom());
    kind = $urandom_range(0, 99);
    case ($urandom_range(0, 9))
      0, 1:    e.idx = 16'($urandom_range(0, 4095));
      2:       e.idx = 16'($urandom());
      default: e.idx = 16'($urandom_range(0, 15));
    endcase
    bytes = type_bytes(e.ftype);
    if (bytes == 0) bytes = 8;
    need  = (32'(e.idx) + 1) * bytes;
    slack = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 16);
    e.raw = {$urandom(), $urandom()};
    if (kind < 70) begin
      e.cnt = ($urandom_range(0, 3) == 0) ? $urandom() : 32'(e.idx) + 1 + $urandom_range(0, 7);
      if (e.cnt <= 32'(e.idx)) e.cnt = 32'(e.idx) + 1;
      e.len = (need + slack > 65535) ? 16'hFFFF : 16'(need + slack);
    end else if (kind < 78) begin
      // index at or past the declared count
      e.cnt = $urandom_range(0, 32'(e.idx));
      e.len = 16'hFFFF - 16'($urandom_range(0, 255));
    end else if (kind < 86) begin
      // buffer one byte short
      e.cnt = 32'(e.idx) + 1 + $urandom_range(0, 7);
      e.len = (need - 1 > 65535) ? 16'hFFFF : 16'(need - 1);
    end else begin
      e.idx = 16'($urandom());
      e.cnt = $urandom();
      e.len = 16'($urandom());
    end
    if ((e.ftype == TYPE_RATIONAL || e.ftype == TYPE_SRATIONAL) && $urandom_range(0, 7) == 0)
      e.raw[63:32] = 32'd0;
    return e;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (error_count < MAX_PRINTS)
      $display("[%0t] mismatch %s: got %h, expected %h", $time, what, got, want);
    error_count++;
  endtask

  // Offer one beat and hold it until accepted; gaps fall between bursts
  task automatic send_item(input entry_t e);
    int gap;
    @(negedge clk);
    if (tx_gaps && burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left != 0) burst_left--;
    in_tvalid = 1'b1;
    in_tdata  = e;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Stop offering, let every queued reading come out, then wait out the drain tail
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  task automatic set_endian(input logic order);
    wait_drained();
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = order;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    file_order  = order;
  endtask

  // Every type code at index 0, then bounds edges and rational corners
  task automatic test_directed_decode();
    rx_mode = RX_RANDOM;
    tx_gaps = 1'b1;
    for (int t = 0; t <= 18; t++)
      send_item(make_item(16'(t), 16'd0, 32'd1, 16'd8, SWEEP_RAW));
    send_item(make_item(16'hFFFF, 16'd0, 32'd1, 16'd8, SWEEP_RAW));
    // index equal to count
    send_item(make_item(TYPE_SHORT, 16'd3, 32'd3, 16'd64, SWEEP_RAW));
    // buffer one byte short, then exactly full
    send_item(make_item(TYPE_LONG, 16'd2, 32'd10, 16'd11, SWEEP_RAW));
    send_item(make_item(TYPE_SLONG, 16'd2, 32'hFFFF_FFFF, 16'd12, SWEEP_RAW));
    // top indices against the largest buffer
    send_item(make_item(TYPE_BYTE, 16'hFFFE, 32'hFFFF_FFFF, 16'hFFFF, SWEEP_RAW));
    send_item(make_item(TYPE_SBYTE, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, SWEEP_RAW));
    // zero denominator
    send_item(make_item(TYPE_RATIONAL, 16'd0, 32'd1, 16'd8, 64'h0000_0000_FFFF_FFFF));
  endtask

  task automatic test_random_mix(input logic order, input int n, input rx_mode_t mode,
                                 input bit gaps);
    set_endian(order);
    rx_mode = mode;
    tx_gaps = gaps;
    repeat (n) send_item(make_entry());
  endtask

  // Receiver holds off while the sender keeps offering back to back
  task automatic test_output_hold(input logic order, input int n);
    set_endian(order);
    rx_mode = RX_ALWAYS;
    tx_gaps = 1'b0;
    @(posedge clk);
    hold_req++;
    repeat (n) send_item(make_entry());
    tx_gaps = 1'b1;
  endtask

  // Sender pauses until every result of a batch is out
  task automatic test_pause_for_results(input logic order, input int rounds, input int n);
    set_endian(order);
    rx_mode = RX_PATTERN;
    tx_gaps = 1'b1;
    repeat (rounds) begin
      repeat (n) send_item(make_entry());
      wait_drained();
    end
  endtask

  // Predict on every accepted input beat
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      expected_readings.insert(expected_readings.size(),
                               decode_element(file_order, in_tdata));
  end

  // Compare every accepted result beat with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_res = out_tdata[$bits(res_t)-1:0];
      if (expected_readings.size() == 0) begin
        report_mismatch("beat with nothing expected", got_res.u_val, 64'd0);
      end else begin
        want_res = expected_readings.pop_front();
        if (got_res.sz !== want_res.sz)
          report_mismatch("elem_size", 64'(got_res.sz), 64'(want_res.sz));
        if (got_res.u_ok !== want_res.u_ok)
          report_mismatch("unsigned_ok", 64'(got_res.u_ok), 64'(want_res.u_ok));
        if (got_res.u_val !== want_res.u_val)
          report_mismatch("unsigned_val", got_res.u_val, want_res.u_val);
        if (got_res.s_ok !== want_res.s_ok)
          report_mismatch("signed_ok", 64'(got_res.s_ok), 64'(want_res.s_ok));
        if (got_res.s_val !== want_res.s_val)
          report_mismatch("signed_val", got_res.s_val, want_res.s_val);
        if (got_res.r_ok !== want_res.r_ok)
          report_mismatch("rational_ok", 64'(got_res.r_ok), 64'(want_res.r_ok));
        if (got_res.num !== want_res.num)
          report_mismatch("rat_numerator", 64'(got_res.num), 64'(want_res.num));
        if (got_res.den !== want_res.den)
          report_mismatch("rat_denominator", 64'(got_res.den), 64'(want_res.den));
      end
    end
  end

  // Receiver: long hold on request, otherwise the current stall pattern
  always @(negedge clk) begin
    rx_tick++;
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      out_tready = 1'b0;
      hold_left--;
    end else begin
      case (rx_mode)
        RX_ALWAYS: out_tready = 1'b1;
        RX_RANDOM: out_tready = ($urandom_range(0, 3) != 0);
        default:   out_tready = ((rx_tick % 11) < 7);
      endcase
    end
  end

  // Watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_tiff_field_value_decoder: errors");
      $finish;
    end
  end

  initial begin
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = ORDER_LE;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    out_tready  = 1'b0;
    file_order  = ORDER_LE;
    error_count = 0;
    burst_left  = 0;
    tx_gaps     = 1'b1;
    rx_mode     = RX_ALWAYS;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // little endian straight from reset
    test_directed_decode();
    test_random_mix(ORDER_BE, 240, RX_RANDOM, 1'b1);
    test_random_mix(ORDER_LE, 240, RX_PATTERN, 1'b1);
    test_random_mix(ORDER_BE, 240, RX_ALWAYS, 1'b0);
    test_random_mix(ORDER_LE, 240, RX_RANDOM, 1'b0);
    test_output_hold(ORDER_BE, 160);
    test_pause_for_results(ORDER_LE, 4, 40);

    wait_drained();
    if (error_count == 0) begin
      $display("tb_tiff_field_value_decoder: clean");
    end else begin
      $display("tb_tiff_field_value_decoder: errors");
    end
    $finish;
  end

endmodule

// File: tiff_field_value_decoder.f
rtl/tfvd_pkg.sv
rtl/tiff_field_value_decoder.sv
tb/tb_tiff_field_value_decoder.sv
